FILE: hdl/vtt_pkg.sv
// Shared types and constants for the vehicle track table.
// Holds command, status and chain-operation codes, the scan token and write structs.
// No dependencies.
package vtt_pkg;

  localparam int unsigned BOX_W    = 11;
  localparam int unsigned CTR_W    = 12;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CTR_W-1:0] SEED_Y_LOW  = 12'd80;
  localparam logic [CTR_W-1:0] SEED_Y_HIGH = 12'd300;

  localparam logic [BOX_W-1:0] RST_ROI_X_MIN  = 11'd300;
  localparam logic [BOX_W-1:0] RST_ROI_X_MAX  = 11'd400;
  localparam logic [BOX_W-1:0] RST_ROI_Y_MIN  = 11'd100;
  localparam logic [BOX_W-1:0] RST_ROI_Y_MAX  = 11'd280;
  localparam logic [BOX_W-1:0] RST_MIN_HEIGHT = 11'd35;
  localparam logic [BOX_W-1:0] RST_MATCH_DX   = 11'd20;
  localparam logic [BOX_W-1:0] RST_MATCH_DY   = 11'd50;
  localparam logic [BOX_W-1:0] RST_ENTRY_Y_MAX = 11'd120;

  typedef enum logic [1:0] {
    CMD_SEED  = 2'd0,
    CMD_TRACK = 2'd1,
    CMD_EOF   = 2'd2,
    CMD_EOSF  = 2'd3
  } vtt_cmd_e;

  typedef enum logic [2:0] {
    ST_REJECTED = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_NEW      = 3'd2,
    ST_UNPLACED = 3'd3,
    ST_FRAME    = 3'd4
  } vtt_status_e;

  typedef enum logic [2:0] {
    REG_ROI_X_MIN  = 3'd0,
    REG_ROI_X_MAX  = 3'd1,
    REG_ROI_Y_MIN  = 3'd2,
    REG_ROI_Y_MAX  = 3'd3,
    REG_MIN_HEIGHT = 3'd4,
    REG_MATCH_DX   = 3'd5,
    REG_MATCH_DY   = 3'd6,
    REG_ENTRY_Y_MAX = 3'd7
  } vtt_reg_e;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_EOF  = 2'd1,
    OP_EOSF = 2'd2
  } vtt_op_e;

  // Token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic             vld;
    vtt_op_e          op;
    logic [CTR_W-1:0] cx;
    logic [CTR_W-1:0] cy;
    logic             found;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] cleared;
  } vtt_tok_t;

  // Direct write of a new entry into one cell.
  typedef struct packed {
    logic             en;
    logic [CTR_W-1:0] x;
    logic [CTR_W-1:0] y;
  } vtt_wr_t;

  typedef struct packed {
    logic [BOX_W-1:0] roi_x_min;
    logic [BOX_W-1:0] roi_x_max;
    logic [BOX_W-1:0] roi_y_min;
    logic [BOX_W-1:0] roi_y_max;
    logic [BOX_W-1:0] min_height;
    logic [BOX_W-1:0] match_dx;
    logic [BOX_W-1:0] match_dy;
    logic [BOX_W-1:0] entry_y_max;
  } vtt_cfg_t;

endpackage

FILE: hdl/vehicle_track_table.sv
// Vehicle track table: a row of slot cells searched by a token that moves one cell per cycle.
// Seed and rejected detections go from S_EVAL straight to S_PUT; tracking detections and frame
//   commands first walk the token along the cell row in S_SCAN, then go to S_PUT.
// Requests are handled one at a time: a new request is accepted only in S_IDLE.
// Reset (asynchronous, active low) empties every slot, clears touched marks, the insert
//   pointer and the output register, and loads the configuration registers with their defaults.
// Depends on vtt_pkg, vtt_qual and vtt_cell.
module vehicle_track_table import vtt_pkg::*; #(
  parameter int unsigned TRACK_SLOTS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // box_x, box_y, box_width, box_height, 4 zero bits
  input  logic [1:0]           s_axis_tuser,  // command
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // slot, center_x, center_y, cleared_count, zeros
  output logic [2:0]           m_axis_tuser,  // status
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BOX_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_PUT
  } state_e;

  state_e            state_q, state_d;
  vtt_cfg_t          cfg_q;
  vtt_cmd_e          cmd_q;
  logic [BOX_W-1:0]  bx_q, by_q, bw_q, bh_q;
  logic [SLOT_W-1:0] ptr_q, ptr_d;

  // Result staged until the output register is free.
  vtt_status_e       res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [CTR_W-1:0]  res_cx_q, res_cx_d, res_cy_q, res_cy_d;
  logic [CNT_W-1:0]  res_clr_q, res_clr_d;

  logic              out_vld_q, out_vld_d;
  vtt_status_e       out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [CTR_W-1:0]  out_cx_q, out_cx_d, out_cy_q, out_cy_d;
  logic [CNT_W-1:0]  out_clr_q, out_clr_d;

  logic [CTR_W-1:0]  cx, cy;
  logic              accept;
  logic              place;
  logic [CTR_W-1:0]  place_x, place_y;
  vtt_tok_t          launch;
  vtt_tok_t          chain [TRACK_SLOTS+1];
  vtt_tok_t          tok_last;
  logic              in_fire;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Configuration registers. Writes must only be issued while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roi_x_min   <= RST_ROI_X_MIN;
      cfg_q.roi_x_max   <= RST_ROI_X_MAX;
      cfg_q.roi_y_min   <= RST_ROI_Y_MIN;
      cfg_q.roi_y_max   <= RST_ROI_Y_MAX;
      cfg_q.min_height  <= RST_MIN_HEIGHT;
      cfg_q.match_dx    <= RST_MATCH_DX;
      cfg_q.match_dy    <= RST_MATCH_DY;
      cfg_q.entry_y_max <= RST_ENTRY_Y_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vtt_reg_e'(cfg_index_i))
        REG_ROI_X_MIN:   cfg_q.roi_x_min   <= cfg_data_i;
        REG_ROI_X_MAX:   cfg_q.roi_x_max   <= cfg_data_i;
        REG_ROI_Y_MIN:   cfg_q.roi_y_min   <= cfg_data_i;
        REG_ROI_Y_MAX:   cfg_q.roi_y_max   <= cfg_data_i;
        REG_MIN_HEIGHT:  cfg_q.min_height  <= cfg_data_i;
        REG_MATCH_DX:    cfg_q.match_dx    <= cfg_data_i;
        REG_MATCH_DY:    cfg_q.match_dy    <= cfg_data_i;
        REG_ENTRY_Y_MAX: cfg_q.entry_y_max <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The request fields are captured so the centre is computed from a register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= vtt_cmd_e'(s_axis_tuser);
      bx_q  <= s_axis_tdata[10:0];
      by_q  <= s_axis_tdata[21:11];
      bw_q  <= s_axis_tdata[32:22];
      bh_q  <= s_axis_tdata[43:33];
    end
  end

  vtt_qual u_qual (
    .cmd_i        (cmd_q),
    .box_x_i      (bx_q),
    .box_y_i      (by_q),
    .box_width_i  (bw_q),
    .box_height_i (bh_q),
    .cfg_i        (cfg_q),
    .cx_o         (cx),
    .cy_o         (cy),
    .accept_o     (accept)
  );

  // The cell row. The token enters cell 0 and passes through the register of each cell in turn to the last cell.
  assign chain[0] = launch;
  assign tok_last = chain[TRACK_SLOTS];

  for (genvar i = 0; i < TRACK_SLOTS; i++) begin : g_cell
    vtt_wr_t wr;
    assign wr.en = place && (ptr_q == SLOT_W'(i));
    assign wr.x  = place_x;
    assign wr.y  = place_y;

    vtt_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1]),
      .wr_i       (wr),
      .match_dx_i (cfg_q.match_dx),
      .match_dy_i (cfg_q.match_dy)
    );
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_cx_d     = res_cx_q;
    res_cy_d     = res_cy_q;
    res_clr_d    = res_clr_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_cx_d     = out_cx_q;
    out_cy_d     = out_cy_q;
    out_clr_d    = out_clr_q;
    place        = 1'b0;
    place_x      = cx;
    place_y      = cy;
    launch       = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_slot_d = '0;
        res_clr_d  = '0;
        res_cx_d   = cx;
        res_cy_d   = cy;
        if (cmd_q == CMD_EOF || cmd_q == CMD_EOSF) begin
          launch.vld = 1'b1;
          launch.op  = (cmd_q == CMD_EOF) ? OP_EOF : OP_EOSF;
          res_cx_d   = '0;
          res_cy_d   = '0;
          state_d    = S_SCAN;
        end else if (!accept) begin
          res_status_d = ST_REJECTED;
          state_d      = S_PUT;
        end else if (cmd_q == CMD_SEED) begin
          // Seed boxes go straight to the insert slot without matching.
          place        = 1'b1;
          res_status_d = ST_NEW;
          res_slot_d   = ptr_q;
          state_d      = S_PUT;
        end else begin
          launch.vld = 1'b1;
          launch.op  = OP_SCAN;
          launch.cx  = cx;
          launch.cy  = cy;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_last.vld) begin
          state_d = S_PUT;
          if (tok_last.op == OP_SCAN) begin
            place_x = tok_last.cx;
            place_y = tok_last.cy;
            if (tok_last.found) begin
              res_status_d = ST_MATCHED;
              res_slot_d   = tok_last.slot;
            end else if (tok_last.cy < {1'b0, cfg_q.entry_y_max}) begin
              place        = 1'b1;
              res_status_d = ST_NEW;
              res_slot_d   = ptr_q;
            end else begin
              res_status_d = ST_UNPLACED;
            end
          end else begin
            res_status_d = ST_FRAME;
            res_clr_d    = (tok_last.op == OP_EOF) ? tok_last.cleared : '0;
          end
        end
      end
      S_PUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_cx_d     = res_cx_q;
          out_cy_d     = res_cy_q;
          out_clr_d    = res_clr_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The insert pointer advances round robin whenever a new entry is written.
    if (place) begin
      ptr_d = (ptr_q == SLOT_W'(TRACK_SLOTS - 1)) ? '0 : ptr_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ptr_q        <= '0;
      out_vld_q    <= 1'b0;
      res_status_q <= ST_REJECTED;
      res_slot_q   <= '0;
      res_cx_q     <= '0;
      res_cy_q     <= '0;
      res_clr_q    <= '0;
      out_status_q <= ST_REJECTED;
      out_slot_q   <= '0;
      out_cx_q     <= '0;
      out_cy_q     <= '0;
      out_clr_q    <= '0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      out_vld_q    <= out_vld_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_cx_q     <= res_cx_d;
      res_cy_q     <= res_cy_d;
      res_clr_q    <= res_clr_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_cx_q     <= out_cx_d;
      out_cy_q     <= out_cy_d;
      out_clr_q    <= out_clr_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'b0, out_clr_q, out_cy_q, out_cx_q, out_slot_q};

  // The token only leaves the row while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.vld |-> (state_q == S_SCAN))
    else $error("token left the cell row outside the scan state");

  // The insert pointer always names an existing slot. The compare is one bit wider so a
  // full sixteen-slot row is covered too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ptr_q} < (SLOT_W+1)'(TRACK_SLOTS))
    else $error("insert pointer beyond the last slot");

  // A new request is only taken when no token is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !chain[1].vld)
    else $error("request accepted while the row was busy");

  // Only frame results carry a cleared count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != ST_FRAME) |-> (out_clr_q == '0))
    else $error("cleared count on a detection result");

endmodule

FILE: hdl/vtt_qual.sv
// Centre computation and acceptance check for one detection box.
// Depends on vtt_pkg.
module vtt_qual import vtt_pkg::*; (
  input  vtt_cmd_e         cmd_i,
  input  logic [BOX_W-1:0] box_x_i,
  input  logic [BOX_W-1:0] box_y_i,
  input  logic [BOX_W-1:0] box_width_i,
  input  logic [BOX_W-1:0] box_height_i,
  input  vtt_cfg_t         cfg_i,
  output logic [CTR_W-1:0] cx_o,
  output logic [CTR_W-1:0] cy_o,
  output logic             accept_o
);

  logic [CTR_W-1:0] y_lo, y_hi;
  logic             seed;

  // (2*x + w) >> 1 equals x + floor(w / 2).
  assign cx_o = {1'b0, box_x_i} + {2'b00, box_width_i[BOX_W-1:1]};
  assign cy_o = {1'b0, box_y_i} + {2'b00, box_height_i[BOX_W-1:1]};

  assign seed = (cmd_i == CMD_SEED);
  assign y_lo = seed ? SEED_Y_LOW  : {1'b0, cfg_i.roi_y_min};
  assign y_hi = seed ? SEED_Y_HIGH : {1'b0, cfg_i.roi_y_max};

  assign accept_o = (cx_o > {1'b0, cfg_i.roi_x_min}) && (cx_o < {1'b0, cfg_i.roi_x_max}) &&
                    (cy_o > y_lo) && (cy_o < y_hi) &&
                    (box_height_i > cfg_i.min_height);

endmodule

FILE: hdl/vtt_cell.sv
// One table slot: holds a track entry and processes the token passing through it.
// Depends on vtt_pkg.
module vtt_cell import vtt_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vtt_tok_t         tok_i,
  output vtt_tok_t         tok_o,
  input  vtt_wr_t          wr_i,
  input  logic [BOX_W-1:0] match_dx_i,
  input  logic [BOX_W-1:0] match_dy_i
);

  logic [CTR_W-1:0] x_q, x_d, y_q, y_d;
  logic             touched_q, touched_d;
  vtt_tok_t         tok_q, tok_d;
  logic [CTR_W-1:0] dx, dy;
  logic             occupied, hit;

  assign dx       = (tok_i.cx > x_q) ? tok_i.cx - x_q : x_q - tok_i.cx;
  assign dy       = (tok_i.cy > y_q) ? tok_i.cy - y_q : y_q - tok_i.cy;
  assign occupied = (x_q != '0);
  assign hit      = occupied && !tok_i.found &&
                    (dx < {1'b0, match_dx_i}) && (dy < {1'b0, match_dy_i});

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    touched_d = touched_q;
    tok_d     = tok_i;
    if (wr_i.en) begin
      x_d       = wr_i.x;
      y_d       = wr_i.y;
      touched_d = 1'b1;
    end else if (tok_i.vld) begin
      case (tok_i.op)
        OP_SCAN: begin
          if (hit) begin
            x_d         = tok_i.cx;
            y_d         = tok_i.cy;
            touched_d   = 1'b1;
            tok_d.found = 1'b1;
            tok_d.slot  = SLOT_W'(IDX);
          end
        end
        OP_EOF: begin
          if (!touched_q) begin
            x_d = '0;
            y_d = '0;
            if (occupied) begin
              tok_d.cleared = tok_i.cleared + CNT_W'(1);
            end
          end
          touched_d = 1'b0;
        end
        OP_EOSF: begin
          touched_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      touched_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      x_q       <= x_d;
      y_q       <= y_d;
      touched_q <= touched_d;
      tok_q     <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
